### design/hsvk_pkg.sv
// ----------------------------------------------------------------------------
// hsvk_pkg
// Shared constants and types for the hsv range color key pipeline.
// ----------------------------------------------------------------------------
package hsvk_pkg;

   // fixed-point formats
   localparam int unsigned HUE_BITS  = 15;      // hue in 1/64 degree
   localparam int unsigned UNIT_BITS = 17;      // q1.16, 65536 is 1.0
   localparam int unsigned QUOT_BITS = 17;      // quotient bits from the divider chain
   localparam int unsigned UNIT_SHIFT = 16;     // fraction bits of q1.16

   localparam int unsigned HUE_FULL    = 23040; // 360 degrees
   localparam int unsigned HUE_SEXTANT = 3840;  // 60 degrees
   localparam int unsigned UNIT_ONE    = 65536;

   // register file
   localparam int unsigned REG_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 17;

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_HUE_CENTER    = 3'd0,
      REG_HUE_HALFWIDTH = 3'd1,
      REG_SAT_CENTER    = 3'd2,
      REG_SAT_HALFWIDTH = 3'd3,
      REG_VAL_CENTER    = 3'd4,
      REG_VAL_HALFWIDTH = 3'd5,
      REG_INVERT_KEY    = 3'd6
   } reg_index_type;

endpackage

### design/hsvk_if.sv
// ----------------------------------------------------------------------------
// hsvk channel interfaces
// Pixel request, keyed pixel response and register write channels.
// ----------------------------------------------------------------------------
interface hsvk_req_if #(parameter int unsigned CHANNEL_BITS = 8);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_in;
   logic [CHANNEL_BITS-1:0] green_in;
   logic [CHANNEL_BITS-1:0] blue_in;
   logic [CHANNEL_BITS-1:0] alpha_in;

   modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface hsvk_rsp_if #(parameter int unsigned CHANNEL_BITS = 8);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_out;
   logic [CHANNEL_BITS-1:0] green_out;
   logic [CHANNEL_BITS-1:0] blue_out;
   logic [CHANNEL_BITS-1:0] alpha_out;
   logic                    keyed_out;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, keyed_out,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, keyed_out,
                   output ready);
endinterface

interface hsvk_csr_if;
   import hsvk_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [REG_INDEX_BITS-1:0] reg_index;
   logic [CSR_DATA_BITS-1:0]  wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### design/hsvk_front.sv
// ----------------------------------------------------------------------------
// hsvk_front
// Two pipeline stages: max/min/delta, then hue and saturation dividends and
// value by folding division by the full-scale channel code.
// ----------------------------------------------------------------------------
module hsvk_front #(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic [CHANNEL_BITS-1:0]                     in_red,
   input  logic [CHANNEL_BITS-1:0]                     in_green,
   input  logic [CHANNEL_BITS-1:0]                     in_blue,
   input  logic [CHANNEL_BITS-1:0]                     in_alpha,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output logic [CHANNEL_BITS-1:0]                     out_red,
   output logic [CHANNEL_BITS-1:0]                     out_green,
   output logic [CHANNEL_BITS-1:0]                     out_blue,
   output logic [CHANNEL_BITS-1:0]                     out_alpha,
   output logic [hsvk_pkg::UNIT_BITS-1:0]              out_val,
   output logic [CHANNEL_BITS+hsvk_pkg::QUOT_BITS-1:0] out_hue_num,
   output logic [CHANNEL_BITS-1:0]                     out_hue_den,
   output logic [CHANNEL_BITS+hsvk_pkg::QUOT_BITS-1:0] out_sat_num,
   output logic [CHANNEL_BITS-1:0]                     out_sat_den,
   output logic                                        out_hue_zero,
   output logic                                        out_sat_zero
);
   import hsvk_pkg::*;

   localparam int unsigned NUM_BITS  = CHANNEL_BITS + QUOT_BITS;
   localparam int unsigned VAL_FOLDS = 4;
   localparam logic [UNIT_BITS-1:0] CHAN_MAX = UNIT_BITS'((1 << CHANNEL_BITS) - 1);

   typedef enum logic [1:0] {
      HUE_RED_UP   = 2'd0,
      HUE_RED_DOWN = 2'd1,
      HUE_GREEN    = 2'd2,
      HUE_BLUE     = 2'd3
   } sextant_type;

   // stage a
   logic                    a_valid_ff;
   logic                    a_ready;
   logic [CHANNEL_BITS-1:0] red_a_ff, green_a_ff, blue_a_ff, alpha_a_ff;
   logic [CHANNEL_BITS-1:0] max_a_ff, max_a_in;
   logic [CHANNEL_BITS-1:0] delta_a_ff, delta_a_in;
   logic [CHANNEL_BITS-1:0] min_val;
   sextant_type             sel_a_ff, sel_a_in;

   // stage b
   logic                    b_valid_ff;
   logic                    b_ready;
   logic [CHANNEL_BITS-1:0] red_b_ff, green_b_ff, blue_b_ff, alpha_b_ff;
   logic [UNIT_BITS-1:0]    val_b_ff, val_b_in;
   logic [UNIT_BITS-1:0]    fold_rem;
   logic [NUM_BITS-1:0]     hue_num_b_ff, hue_num_b_in;
   logic [NUM_BITS-1:0]     sat_num_b_ff;
   logic [CHANNEL_BITS-1:0] delta_b_ff, max_b_ff;

   assign a_ready  = !a_valid_ff || b_ready;
   assign b_ready  = !b_valid_ff || out_ready;
   assign in_ready = a_ready;

   always_comb begin
      max_a_in = in_red;
      min_val  = in_red;
      if (in_green > max_a_in) max_a_in = in_green;
      if (in_blue > max_a_in) max_a_in = in_blue;
      if (in_green < min_val) min_val = in_green;
      if (in_blue < min_val) min_val = in_blue;
      delta_a_in = max_a_in - min_val;
      // red wins ties, then green
      if (in_red == max_a_in) begin
         sel_a_in = (in_green >= in_blue) ? HUE_RED_UP : HUE_RED_DOWN;
      end else if (in_green == max_a_in) begin
         sel_a_in = HUE_GREEN;
      end else begin
         sel_a_in = HUE_BLUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (in_valid && a_ready) begin
         red_a_ff   <= in_red;
         green_a_ff <= in_green;
         blue_a_ff  <= in_blue;
         alpha_a_ff <= in_alpha;
         max_a_ff   <= max_a_in;
         delta_a_ff <= delta_a_in;
         sel_a_ff   <= sel_a_in;
      end
   end

   // hue dividend, always nonnegative in each sextant
   always_comb begin
      case (sel_a_ff)
         HUE_RED_UP: begin
            hue_num_b_in = NUM_BITS'(HUE_SEXTANT) * NUM_BITS'(green_a_ff - blue_a_ff);
         end
         HUE_RED_DOWN: begin
            hue_num_b_in = NUM_BITS'(HUE_FULL) * NUM_BITS'(delta_a_ff)
                         - NUM_BITS'(HUE_SEXTANT) * NUM_BITS'(blue_a_ff - green_a_ff);
         end
         HUE_GREEN: begin
            hue_num_b_in = NUM_BITS'(2 * HUE_SEXTANT) * NUM_BITS'(delta_a_ff)
                         + NUM_BITS'(HUE_SEXTANT) * NUM_BITS'(blue_a_ff)
                         - NUM_BITS'(HUE_SEXTANT) * NUM_BITS'(red_a_ff);
         end
         default: begin
            hue_num_b_in = NUM_BITS'(4 * HUE_SEXTANT) * NUM_BITS'(delta_a_ff)
                         + NUM_BITS'(HUE_SEXTANT) * NUM_BITS'(red_a_ff)
                         - NUM_BITS'(HUE_SEXTANT) * NUM_BITS'(green_a_ff);
         end
      endcase
   end

   // value = max * 2^16 / (2^n - 1): fold high part onto low part, since
   // 2^n is one more than the divisor, then one final correction
   always_comb begin
      fold_rem = UNIT_BITS'(max_a_ff) << (UNIT_SHIFT - CHANNEL_BITS);
      val_b_in = fold_rem;
      for (int k = 0; k < VAL_FOLDS; k++) begin
         val_b_in = val_b_in + (fold_rem >> CHANNEL_BITS);
         fold_rem = (fold_rem >> CHANNEL_BITS) + (fold_rem & CHAN_MAX);
      end
      if (fold_rem >= CHAN_MAX) val_b_in = val_b_in + UNIT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (a_valid_ff && b_ready) begin
         red_b_ff     <= red_a_ff;
         green_b_ff   <= green_a_ff;
         blue_b_ff    <= blue_a_ff;
         alpha_b_ff   <= alpha_a_ff;
         val_b_ff     <= val_b_in;
         hue_num_b_ff <= hue_num_b_in;
         sat_num_b_ff <= NUM_BITS'(delta_a_ff) << UNIT_SHIFT;
         delta_b_ff   <= delta_a_ff;
         max_b_ff     <= max_a_ff;
      end
   end

   assign out_valid    = b_valid_ff;
   assign out_red      = red_b_ff;
   assign out_green    = green_b_ff;
   assign out_blue     = blue_b_ff;
   assign out_alpha    = alpha_b_ff;
   assign out_val      = val_b_ff;
   assign out_hue_num  = hue_num_b_ff;
   assign out_hue_den  = delta_b_ff;
   assign out_sat_num  = sat_num_b_ff;
   assign out_sat_den  = max_b_ff;
   assign out_hue_zero = (delta_b_ff == '0);
   assign out_sat_zero = (max_b_ff == '0);

endmodule

### design/hsvk_div_stage.sv
// ----------------------------------------------------------------------------
// hsvk_div_stage
// One restoring-division step for hue and saturation side by side, with
// its own elastic register and a sideband that rides along.
// ----------------------------------------------------------------------------
module hsvk_div_stage #(
   parameter int unsigned CHANNEL_BITS = 8,
   parameter int unsigned SHIFT        = 0,
   parameter int unsigned SIDE_BITS    = 1
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic [CHANNEL_BITS+hsvk_pkg::QUOT_BITS-1:0] in_hue_rem,
   input  logic [CHANNEL_BITS-1:0]                     in_hue_den,
   input  logic [hsvk_pkg::QUOT_BITS-1:0]              in_hue_quot,
   input  logic [CHANNEL_BITS+hsvk_pkg::QUOT_BITS-1:0] in_sat_rem,
   input  logic [CHANNEL_BITS-1:0]                     in_sat_den,
   input  logic [hsvk_pkg::QUOT_BITS-1:0]              in_sat_quot,
   input  logic [SIDE_BITS-1:0]                        in_side,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output logic [CHANNEL_BITS+hsvk_pkg::QUOT_BITS-1:0] out_hue_rem,
   output logic [CHANNEL_BITS-1:0]                     out_hue_den,
   output logic [hsvk_pkg::QUOT_BITS-1:0]              out_hue_quot,
   output logic [CHANNEL_BITS+hsvk_pkg::QUOT_BITS-1:0] out_sat_rem,
   output logic [CHANNEL_BITS-1:0]                     out_sat_den,
   output logic [hsvk_pkg::QUOT_BITS-1:0]              out_sat_quot,
   output logic [SIDE_BITS-1:0]                        out_side
);
   import hsvk_pkg::*;

   localparam int unsigned NUM_BITS = CHANNEL_BITS + QUOT_BITS;

   logic                    valid_ff;
   logic [NUM_BITS-1:0]     hue_step, sat_step;
   logic                    hue_take, sat_take;
   logic [NUM_BITS-1:0]     hue_rem_ff, hue_rem_in, sat_rem_ff, sat_rem_in;
   logic [CHANNEL_BITS-1:0] hue_den_ff, sat_den_ff;
   logic [QUOT_BITS-1:0]    hue_quot_ff, sat_quot_ff;
   logic [SIDE_BITS-1:0]    side_ff;

   assign hue_step   = NUM_BITS'(in_hue_den) << SHIFT;
   assign sat_step   = NUM_BITS'(in_sat_den) << SHIFT;
   assign hue_take   = (in_hue_rem >= hue_step);
   assign sat_take   = (in_sat_rem >= sat_step);
   assign hue_rem_in = hue_take ? in_hue_rem - hue_step : in_hue_rem;
   assign sat_rem_in = sat_take ? in_sat_rem - sat_step : in_sat_rem;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         hue_rem_ff  <= hue_rem_in;
         sat_rem_ff  <= sat_rem_in;
         hue_den_ff  <= in_hue_den;
         sat_den_ff  <= in_sat_den;
         hue_quot_ff <= {in_hue_quot[QUOT_BITS-2:0], hue_take};
         sat_quot_ff <= {in_sat_quot[QUOT_BITS-2:0], sat_take};
         side_ff     <= in_side;
      end
   end

   assign out_valid    = valid_ff;
   assign out_hue_rem  = hue_rem_ff;
   assign out_hue_den  = hue_den_ff;
   assign out_hue_quot = hue_quot_ff;
   assign out_sat_rem  = sat_rem_ff;
   assign out_sat_den  = sat_den_ff;
   assign out_sat_quot = sat_quot_ff;
   assign out_side     = side_ff;

endmodule

### design/hsvk_window.sv
// ----------------------------------------------------------------------------
// hsvk_window
// Key registers, window bounds, in-window test stage and output register.
// ----------------------------------------------------------------------------
module hsvk_window #(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   hsvk_csr_if.sink                       csr_chan,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [hsvk_pkg::QUOT_BITS-1:0] in_hue_quot,
   input  logic [hsvk_pkg::QUOT_BITS-1:0] in_sat_quot,
   input  logic [hsvk_pkg::UNIT_BITS-1:0] in_val,
   input  logic                           in_hue_zero,
   input  logic                           in_sat_zero,
   input  logic [CHANNEL_BITS-1:0]        in_red,
   input  logic [CHANNEL_BITS-1:0]        in_green,
   input  logic [CHANNEL_BITS-1:0]        in_blue,
   input  logic [CHANNEL_BITS-1:0]        in_alpha,
   hsvk_rsp_if.source                     rsp_chan
);
   import hsvk_pkg::*;

   // key registers
   logic [HUE_BITS-1:0]  hue_center_ff, hue_half_ff;
   logic [UNIT_BITS-1:0] sat_center_ff, sat_half_ff, val_center_ff, val_half_ff;
   logic                 invert_ff;

   // window bounds
   logic [HUE_BITS:0]    hue_top;
   logic [UNIT_BITS:0]   sat_top, val_top;
   logic [HUE_BITS-1:0]  hue_lo_ff, hue_lo_in, hue_hi_ff, hue_hi_in;
   logic [UNIT_BITS-1:0] sat_lo_ff, sat_lo_in, sat_hi_ff, sat_hi_in;
   logic [UNIT_BITS-1:0] val_lo_ff, val_lo_in, val_hi_ff, val_hi_in;

   // test stage
   logic                    c_valid_ff, c_ready;
   logic                    inside_ff, inside_in;
   logic [QUOT_BITS-1:0]    hue_val, sat_val;
   logic [CHANNEL_BITS-1:0] red_c_ff, green_c_ff, blue_c_ff, alpha_c_ff;

   // output stage
   logic                    d_valid_ff, d_ready;
   logic                    keyed_in, keyed_ff;
   logic [CHANNEL_BITS-1:0] red_d_ff, green_d_ff, blue_d_ff, alpha_d_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_center_ff <= '0;
         hue_half_ff   <= '0;
         sat_center_ff <= '0;
         sat_half_ff   <= '0;
         val_center_ff <= '0;
         val_half_ff   <= '0;
         invert_ff     <= 1'b0;
      end else if (csr_chan.valid) begin
         case (reg_index_type'(csr_chan.reg_index))
            REG_HUE_CENTER:    hue_center_ff <= csr_chan.wdata[HUE_BITS-1:0];
            REG_HUE_HALFWIDTH: hue_half_ff   <= csr_chan.wdata[HUE_BITS-1:0];
            REG_SAT_CENTER:    sat_center_ff <= csr_chan.wdata[UNIT_BITS-1:0];
            REG_SAT_HALFWIDTH: sat_half_ff   <= csr_chan.wdata[UNIT_BITS-1:0];
            REG_VAL_CENTER:    val_center_ff <= csr_chan.wdata[UNIT_BITS-1:0];
            REG_VAL_HALFWIDTH: val_half_ff   <= csr_chan.wdata[UNIT_BITS-1:0];
            REG_INVERT_KEY:    invert_ff     <= csr_chan.wdata[0];
            default: ;
         endcase
      end
   end

   // center -/+ halfwidth, clamped to 0 and the component limit
   always_comb begin
      hue_top   = {1'b0, hue_center_ff} + {1'b0, hue_half_ff};
      sat_top   = {1'b0, sat_center_ff} + {1'b0, sat_half_ff};
      val_top   = {1'b0, val_center_ff} + {1'b0, val_half_ff};
      hue_lo_in = (hue_center_ff > hue_half_ff) ? hue_center_ff - hue_half_ff : '0;
      sat_lo_in = (sat_center_ff > sat_half_ff) ? sat_center_ff - sat_half_ff : '0;
      val_lo_in = (val_center_ff > val_half_ff) ? val_center_ff - val_half_ff : '0;
      hue_hi_in = (hue_top > (HUE_BITS+1)'(HUE_FULL)) ? HUE_BITS'(HUE_FULL)
                                                       : hue_top[HUE_BITS-1:0];
      sat_hi_in = (sat_top > (UNIT_BITS+1)'(UNIT_ONE)) ? UNIT_BITS'(UNIT_ONE)
                                                        : sat_top[UNIT_BITS-1:0];
      val_hi_in = (val_top > (UNIT_BITS+1)'(UNIT_ONE)) ? UNIT_BITS'(UNIT_ONE)
                                                        : val_top[UNIT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      hue_lo_ff <= hue_lo_in;
      hue_hi_ff <= hue_hi_in;
      sat_lo_ff <= sat_lo_in;
      sat_hi_ff <= sat_hi_in;
      val_lo_ff <= val_lo_in;
      val_hi_ff <= val_hi_in;
   end

   // grey gives hue 0, black gives saturation 0
   assign hue_val = in_hue_zero ? '0 : in_hue_quot;
   assign sat_val = in_sat_zero ? '0 : in_sat_quot;

   assign inside_in = (hue_val >= QUOT_BITS'(hue_lo_ff)) && (hue_val <= QUOT_BITS'(hue_hi_ff))
                   && (sat_val >= QUOT_BITS'(sat_lo_ff)) && (sat_val <= QUOT_BITS'(sat_hi_ff))
                   && (in_val >= val_lo_ff) && (in_val <= val_hi_ff);

   assign d_ready  = !d_valid_ff || rsp_chan.ready;
   assign c_ready  = !c_valid_ff || d_ready;
   assign in_ready = c_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= in_valid;
      end
      if (in_valid && c_ready) begin
         inside_ff  <= inside_in;
         red_c_ff   <= in_red;
         green_c_ff <= in_green;
         blue_c_ff  <= in_blue;
         alpha_c_ff <= in_alpha;
      end
   end

   assign keyed_in = inside_ff ^ invert_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_ready) begin
         d_valid_ff <= c_valid_ff;
      end
      if (c_valid_ff && d_ready) begin
         keyed_ff   <= keyed_in;
         red_d_ff   <= keyed_in ? '0 : red_c_ff;
         green_d_ff <= keyed_in ? '0 : green_c_ff;
         blue_d_ff  <= keyed_in ? '0 : blue_c_ff;
         alpha_d_ff <= keyed_in ? '0 : alpha_c_ff;
      end
   end

   assign rsp_chan.valid     = d_valid_ff;
   assign rsp_chan.keyed_out = keyed_ff;
   assign rsp_chan.red_out   = red_d_ff;
   assign rsp_chan.green_out = green_d_ff;
   assign rsp_chan.blue_out  = blue_d_ff;
   assign rsp_chan.alpha_out = alpha_d_ff;

endmodule

### design/hsv_range_color_key.sv
// path: req accept, front stages, divider chain, window stages, then rsp valid
// throughput: one pixel per cycle unless rsp stalls; 17-step divider fully staged
// every stage is elastic, so a stalled rsp only holds stages that are full
// reset: synchronous, clears all valid bits and key registers, no clearing pass
// ----------------------------------------------------------------------------
// hsv_range_color_key
// Converts each rgba pixel to hsv and clears it when its in-window test
// disagrees with the invert setting.
// ----------------------------------------------------------------------------
module hsv_range_color_key #(
   parameter int unsigned CHANNEL_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   hsvk_req_if.sink   req_chan,
   hsvk_rsp_if.source rsp_chan,
   hsvk_csr_if.sink   csr_chan
);
   import hsvk_pkg::*;

   localparam int unsigned NUM_BITS   = CHANNEL_BITS + QUOT_BITS;
   localparam int unsigned DIV_STAGES = QUOT_BITS;
   // sideband: alpha, blue, green, red, value, hue-zero, sat-zero
   localparam int unsigned SIDE_BITS  = 4 * CHANNEL_BITS + UNIT_BITS + 2;

   // front end outputs
   logic                    front_valid, front_ready;
   logic [CHANNEL_BITS-1:0] front_red, front_green, front_blue, front_alpha;
   logic [UNIT_BITS-1:0]    front_val;
   logic                    front_hue_zero, front_sat_zero;

   // divider chain, index k feeds stage k
   logic [DIV_STAGES:0]     div_valid, div_ready;
   logic [NUM_BITS-1:0]     hue_rem  [DIV_STAGES+1];
   logic [CHANNEL_BITS-1:0] hue_den  [DIV_STAGES+1];
   logic [QUOT_BITS-1:0]    hue_quot [DIV_STAGES+1];
   logic [NUM_BITS-1:0]     sat_rem  [DIV_STAGES+1];
   logic [CHANNEL_BITS-1:0] sat_den  [DIV_STAGES+1];
   logic [QUOT_BITS-1:0]    sat_quot [DIV_STAGES+1];
   logic [SIDE_BITS-1:0]    side     [DIV_STAGES+1];

   // unpacked sideband at the end of the chain
   logic [CHANNEL_BITS-1:0] tail_red, tail_green, tail_blue, tail_alpha;
   logic [UNIT_BITS-1:0]    tail_val;
   logic                    tail_hue_zero, tail_sat_zero;

   // stages 1-2: max/min/delta, then dividends, divisors and value
   hsvk_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_ready     (front_ready),
      .in_red       (req_chan.red_in),
      .in_green     (req_chan.green_in),
      .in_blue      (req_chan.blue_in),
      .in_alpha     (req_chan.alpha_in),
      .out_valid    (front_valid),
      .out_ready    (div_ready[0]),
      .out_red      (front_red),
      .out_green    (front_green),
      .out_blue     (front_blue),
      .out_alpha    (front_alpha),
      .out_val      (front_val),
      .out_hue_num  (hue_rem[0]),
      .out_hue_den  (hue_den[0]),
      .out_sat_num  (sat_rem[0]),
      .out_sat_den  (sat_den[0]),
      .out_hue_zero (front_hue_zero),
      .out_sat_zero (front_sat_zero)
   );

   assign req_chan.ready = front_ready;
   assign div_valid[0]   = front_valid;
   assign hue_quot[0]    = '0;
   assign sat_quot[0]    = '0;
   assign side[0]        = {front_alpha, front_blue, front_green, front_red,
                            front_val, front_hue_zero, front_sat_zero};

   // stages 3-19: one quotient bit per stage, msb first; hue and saturation
   // are divided side by side so the pixel needs no reordering
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      hsvk_div_stage #(
         .CHANNEL_BITS (CHANNEL_BITS),
         .SHIFT        (DIV_STAGES - 1 - k),
         .SIDE_BITS    (SIDE_BITS)
      ) u_stage (
         .clock        (clock),
         .reset        (reset),
         .in_valid     (div_valid[k]),
         .in_ready     (div_ready[k]),
         .in_hue_rem   (hue_rem[k]),
         .in_hue_den   (hue_den[k]),
         .in_hue_quot  (hue_quot[k]),
         .in_sat_rem   (sat_rem[k]),
         .in_sat_den   (sat_den[k]),
         .in_sat_quot  (sat_quot[k]),
         .in_side      (side[k]),
         .out_valid    (div_valid[k+1]),
         .out_ready    (div_ready[k+1]),
         .out_hue_rem  (hue_rem[k+1]),
         .out_hue_den  (hue_den[k+1]),
         .out_hue_quot (hue_quot[k+1]),
         .out_sat_rem  (sat_rem[k+1]),
         .out_sat_den  (sat_den[k+1]),
         .out_sat_quot (sat_quot[k+1]),
         .out_side     (side[k+1])
      );
   end

   assign {tail_alpha, tail_blue, tail_green, tail_red,
           tail_val, tail_hue_zero, tail_sat_zero} = side[DIV_STAGES];

   // stages 20-21: window test, then keyed output register
   hsvk_window #(.CHANNEL_BITS(CHANNEL_BITS)) u_window (
      .clock       (clock),
      .reset       (reset),
      .csr_chan    (csr_chan),
      .in_valid    (div_valid[DIV_STAGES]),
      .in_ready    (div_ready[DIV_STAGES]),
      .in_hue_quot (hue_quot[DIV_STAGES]),
      .in_sat_quot (sat_quot[DIV_STAGES]),
      .in_val      (tail_val),
      .in_hue_zero (tail_hue_zero),
      .in_sat_zero (tail_sat_zero),
      .in_red      (tail_red),
      .in_green    (tail_green),
      .in_blue     (tail_blue),
      .in_alpha    (tail_alpha),
      .rsp_chan    (rsp_chan)
   );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv range color key testbench
// Streams rgba pixels through the keyer under a series of hsv windows and
// checks every keyed pixel against a local hsv conversion and window test.
// ----------------------------------------------------------------------------
module testbench;
   import hsvk_pkg::*;

   localparam int unsigned PIX_BITS        = 8;
   localparam int unsigned PIX_MAX         = (1 << PIX_BITS) - 1;
   localparam logic [REG_INDEX_BITS-1:0] REG_UNMAPPED = 3'd7;
   localparam int unsigned HOLD_OFF_CYCLES = 300;    // long rsp stall, fills the pipe
   localparam int unsigned STALL_LIMIT     = 5000;   // cycles with no transaction at all
   localparam int unsigned TAIL_CYCLES     = 40;     // margin after the final drain
   localparam int unsigned MAX_REPORTS     = 10;
   localparam int unsigned RANDOM_PHASES   = 12;

   typedef struct packed {
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
      logic [PIX_BITS-1:0] alpha;
   } rgba_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
      logic [PIX_BITS-1:0] alpha;
      logic                keyed;
   } keyed_rgba_type;

   typedef struct {
      int unsigned hue;
      int unsigned sat;
      int unsigned val;
   } hsv_type;

   // ------------------------------------------------------------------------
   // clock, reset, channels and the block
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   hsvk_req_if #(.CHANNEL_BITS(PIX_BITS)) req_chan ();
   hsvk_rsp_if #(.CHANNEL_BITS(PIX_BITS)) rsp_chan ();
   hsvk_csr_if                            csr_chan ();

   hsv_range_color_key #(.CHANNEL_BITS(PIX_BITS)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // ------------------------------------------------------------------------
   // mirrored key settings and the queue of pixels still owed by the block
   // ------------------------------------------------------------------------
   logic [HUE_BITS-1:0]  key_hue_center = '0;
   logic [HUE_BITS-1:0]  key_hue_half   = '0;
   logic [UNIT_BITS-1:0] key_sat_center = '0;
   logic [UNIT_BITS-1:0] key_sat_half   = '0;
   logic [UNIT_BITS-1:0] key_val_center = '0;
   logic [UNIT_BITS-1:0] key_val_half   = '0;
   logic                 key_invert     = 1'b0;

   keyed_rgba_type pending_pixels[$];
   int unsigned mismatch_count    = 0;
   int unsigned hold_off_requests = 0;
   int unsigned hold_off_served   = 0;
   int unsigned quiet_cycles      = 0;
   bit          idle_gaps         = 1'b1;

   // ------------------------------------------------------------------------
   // hsv conversion and window test
   // ------------------------------------------------------------------------
   function automatic hsv_type pixel_to_hsv(rgba_type px);
      int unsigned r, g, b, top, bottom, span, num;
      hsv_type c;
      r = 32'(px.red);
      g = 32'(px.green);
      b = 32'(px.blue);
      top = r;
      bottom = r;
      if (g > top) top = g;
      if (b > top) top = b;
      if (g < bottom) bottom = g;
      if (b < bottom) bottom = b;
      span = top - bottom;
      c.val = top * UNIT_ONE / PIX_MAX;
      // black has no saturation
      c.sat = (top != 0) ? span * UNIT_ONE / top : 0;
      // grey has hue 0; ties resolve red first, then green
      c.hue = 0;
      if (span != 0) begin
         if (r == top) begin
            if (g >= b) num = HUE_SEXTANT * (g - b);
            else        num = HUE_FULL * span - HUE_SEXTANT * (b - g);
         end else if (g == top) begin
            num = 2 * HUE_SEXTANT * span + HUE_SEXTANT * b - HUE_SEXTANT * r;
         end else begin
            num = 4 * HUE_SEXTANT * span + HUE_SEXTANT * r - HUE_SEXTANT * g;
         end
         c.hue = num / span;
      end
      return c;
   endfunction

   // bounds are inclusive; a low bound above the limit matches nothing
   function automatic bit in_window(int unsigned x, int unsigned center,
                                    int unsigned half, int unsigned limit);
      int unsigned lo, hi;
      lo = (center > half) ? center - half : 0;
      hi = (center + half > limit) ? limit : center + half;
      return (x >= lo) && (x <= hi);
   endfunction

   function automatic keyed_rgba_type predict_keyed(rgba_type px);
      hsv_type        c;
      bit             hit;
      keyed_rgba_type res;
      c = pixel_to_hsv(px);
      hit = in_window(c.hue, 32'(key_hue_center), 32'(key_hue_half), HUE_FULL) &&
            in_window(c.sat, 32'(key_sat_center), 32'(key_sat_half), UNIT_ONE) &&
            in_window(c.val, 32'(key_val_center), 32'(key_val_half), UNIT_ONE);
      if (hit != key_invert) begin
         res = '0;
         res.keyed = 1'b1;
      end else begin
         res = {px.red, px.green, px.blue, px.alpha, 1'b0};
      end
      return res;
   endfunction

   function automatic void apply_reg_write(logic [REG_INDEX_BITS-1:0] idx,
                                           logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         REG_HUE_CENTER:    key_hue_center = data[HUE_BITS-1:0];
         REG_HUE_HALFWIDTH: key_hue_half   = data[HUE_BITS-1:0];
         REG_SAT_CENTER:    key_sat_center = data[UNIT_BITS-1:0];
         REG_SAT_HALFWIDTH: key_sat_half   = data[UNIT_BITS-1:0];
         REG_VAL_CENTER:    key_val_center = data[UNIT_BITS-1:0];
         REG_VAL_HALFWIDTH: key_val_half   = data[UNIT_BITS-1:0];
         REG_INVERT_KEY:    key_invert     = data[0];
         default: ;  // unmapped index, write is dropped
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // pixel generators
   // ------------------------------------------------------------------------
   function automatic rgba_type rand_pixel();
      rgba_type px;
      px = $urandom;
      case ($urandom_range(0, 7))
         0: begin  // grey
            px.green = px.red;
            px.blue  = px.red;
         end
         1: begin  // one channel at full scale
            case ($urandom_range(0, 2))
               0: px.red   = PIX_BITS'(PIX_MAX);
               1: px.green = PIX_BITS'(PIX_MAX);
               default: px.blue = PIX_BITS'(PIX_MAX);
            endcase
         end
         2: begin  // two channels tied, exercises max tie order
            if ($urandom_range(0, 1)) px.green = px.red;
            else                      px.blue  = px.green;
         end
         3: begin  // corners of the color cube
            px.red   = $urandom_range(0, 1) ? PIX_BITS'(PIX_MAX) : '0;
            px.green = $urandom_range(0, 1) ? PIX_BITS'(PIX_MAX) : '0;
            px.blue  = $urandom_range(0, 1) ? PIX_BITS'(PIX_MAX) : '0;
         end
         default: ;
      endcase
      return px;
   endfunction

   function automatic logic [PIX_BITS-1:0] nudge(logic [PIX_BITS-1:0] chan);
      int x;
      x = int'(chan) + int'($urandom_range(0, 8)) - 4;
      if (x < 0) x = 0;
      if (x > int'(PIX_MAX)) x = PIX_MAX;
      return x[PIX_BITS-1:0];
   endfunction

   // pixels close to a seed so that a window built around it sees hits and misses
   function automatic rgba_type near_pixel(rgba_type seed);
      rgba_type px;
      px.red   = nudge(seed.red);
      px.green = nudge(seed.green);
      px.blue  = nudge(seed.blue);
      px.alpha = PIX_BITS'($urandom);
      return px;
   endfunction

   function automatic int unsigned pick_half(int unsigned span);
      case ($urandom_range(0, 3))
         0: return 0;
         1: return $urandom_range(0, span / 64);
         2: return $urandom_range(0, span / 8);
         default: return $urandom_range(0, span);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // channel tasks
   // ------------------------------------------------------------------------
   // valid stays high across back to back writes, load_key lowers it
   task automatic write_reg(input logic [REG_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wdata     <= data;
      do @(posedge clock); while (!csr_chan.ready);
      apply_reg_write(idx, data);
   endtask

   task automatic load_key(input logic [CSR_DATA_BITS-1:0] hue_c, hue_h,
                           input logic [CSR_DATA_BITS-1:0] sat_c, sat_h,
                           input logic [CSR_DATA_BITS-1:0] val_c, val_h,
                           input logic [CSR_DATA_BITS-1:0] invert_word);
      write_reg(REG_HUE_CENTER,    hue_c);
      write_reg(REG_HUE_HALFWIDTH, hue_h);
      write_reg(REG_SAT_CENTER,    sat_c);
      write_reg(REG_SAT_HALFWIDTH, sat_h);
      write_reg(REG_VAL_CENTER,    val_c);
      write_reg(REG_VAL_HALFWIDTH, val_h);
      write_reg(REG_INVERT_KEY,    invert_word);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // window centered on the seed's hsv, or raw words when raw is set
   task automatic load_key_near(input rgba_type seed, input bit raw);
      hsv_type c;
      c = pixel_to_hsv(seed);
      if (raw) begin
         load_key(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                  CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                  CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom),
                  CSR_DATA_BITS'($urandom));
      end else begin
         load_key(CSR_DATA_BITS'(c.hue), CSR_DATA_BITS'(pick_half(HUE_FULL)),
                  CSR_DATA_BITS'(c.sat), CSR_DATA_BITS'(pick_half(UNIT_ONE)),
                  CSR_DATA_BITS'(c.val), CSR_DATA_BITS'(pick_half(UNIT_ONE)),
                  CSR_DATA_BITS'({$urandom_range(0, 65535), 1'($urandom_range(0, 1))}));
      end
   endtask

   task automatic send_pixel(input rgba_type px);
      if (idle_gaps && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.red_in   <= px.red;
      req_chan.green_in <= px.green;
      req_chan.blue_in  <= px.blue;
      req_chan.alpha_in <= px.alpha;
      do @(posedge clock); while (!req_chan.ready);
      pending_pixels.push_back(predict_keyed(px));
   endtask

   task automatic stop_stream();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // every pixel yields one result, so an empty queue means the pipe is empty
   task automatic wait_drain();
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // all windows collapse to zero after reset, so only black is inside
   task automatic test_reset_values();
      write_reg(REG_UNMAPPED, '1);  // must not disturb any register
      csr_chan.valid <= 1'b0;
      @(posedge clock);
      send_pixel('{red: 0, green: 0, blue: 0, alpha: 8'hFF});
      send_pixel('{red: 255, green: 255, blue: 255, alpha: 8'h00});
      send_pixel('{red: 128, green: 128, blue: 128, alpha: 8'h5A});
      stop_stream();
      wait_drain();
   endtask

   task automatic test_named_colors();
      rgba_type colors[12];
      colors = '{
         '{red: 0,   green: 0,   blue: 0,   alpha: 255},  // black
         '{red: 255, green: 255, blue: 255, alpha: 0},    // white
         '{red: 77,  green: 77,  blue: 77,  alpha: 128},  // grey
         '{red: 255, green: 0,   blue: 0,   alpha: 170},  // red
         '{red: 0,   green: 255, blue: 0,   alpha: 85},   // green
         '{red: 0,   green: 0,   blue: 255, alpha: 1},    // blue
         '{red: 255, green: 255, blue: 0,   alpha: 254},  // yellow, red wins the tie
         '{red: 0,   green: 255, blue: 255, alpha: 15},   // cyan, green wins the tie
         '{red: 255, green: 0,   blue: 255, alpha: 240},  // magenta, hue wraps
         '{red: 255, green: 0,   blue: 1,   alpha: 99},   // just below 360 degrees
         '{red: 1,   green: 0,   blue: 0,   alpha: 200},  // smallest nonzero
         '{red: 10,  green: 200, blue: 100, alpha: 42}
      };
      // fully open window: every pixel keyed
      load_key(11520, 11520, 32768, 32768, 32768, 32768, 0);
      foreach (colors[i]) send_pixel(colors[i]);
      stop_stream();
      wait_drain();
      // point window on pure green, inverted: all but green are cleared
      load_key(CSR_DATA_BITS'(2 * HUE_SEXTANT), 0, CSR_DATA_BITS'(UNIT_ONE), 0,
               CSR_DATA_BITS'(UNIT_ONE), 0, 1);
      foreach (colors[i]) send_pixel(colors[i]);
      stop_stream();
      wait_drain();
   endtask

   task automatic test_window_clamps();
      // hue center past 360: the low bound exceeds the limit
      load_key(17'h07FFF, 0, 32768, 32768, 32768, 32768, 0);
      repeat (30) send_pixel(rand_pixel());
      stop_stream();
      wait_drain();
      // huge half-widths clamp both ends, inverted clears nothing
      load_key(0, 17'h07FFF, 0, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
      repeat (30) send_pixel(rand_pixel());
      stop_stream();
      wait_drain();
      // saturation window pinned to the very top
      load_key(11520, 11520, 17'h1FFFF, CSR_DATA_BITS'(UNIT_ONE), 32768, 32768, 0);
      repeat (30) send_pixel(rand_pixel());
      stop_stream();
      wait_drain();
   endtask

   task automatic test_random_windows();
      rgba_type seed;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         seed = rand_pixel();
         load_key_near(seed, $urandom_range(0, 3) == 0);
         repeat (65) begin
            if ($urandom_range(0, 1)) send_pixel(near_pixel(seed));
            else                      send_pixel(rand_pixel());
         end
         stop_stream();
         wait_drain();
      end
   endtask

   // rsp holds off while pixels keep coming, then the sender waits for a full drain
   task automatic test_backpressure();
      rgba_type seed;
      seed = rand_pixel();
      load_key_near(seed, 1'b0);
      hold_off_requests <= hold_off_requests + 1;
      repeat (60) send_pixel(near_pixel(seed));
      stop_stream();
      wait_drain();
      repeat (30) send_pixel(rand_pixel());
      stop_stream();
      wait_drain();
   endtask

   task automatic test_steady_stream();
      rgba_type seed;
      seed = rand_pixel();
      load_key_near(seed, 1'b0);
      repeat (80) begin
         if ($urandom_range(0, 1)) send_pixel(near_pixel(seed));
         else                      send_pixel(rand_pixel());
      end
      stop_stream();
      wait_drain();
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.red_in    <= '0;
      req_chan.green_in  <= '0;
      req_chan.blue_in   <= '0;
      req_chan.alpha_in  <= '0;
      csr_chan.valid     <= 1'b0;
      csr_chan.reg_index <= '0;
      csr_chan.wdata     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_named_colors();
      test_window_clamps();
      test_random_windows();
      test_backpressure();
      // last part runs with no idling on either side
      idle_gaps = 1'b0;
      test_steady_stream();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // rsp ready: random stall bursts, plus one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_served != hold_off_requests) begin
            hold_off_served <= hold_off_served + 1;
            rsp_chan.ready  <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (idle_gaps && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result check: each rsp transaction against the oldest pending pixel
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      keyed_rgba_type want;
      keyed_rgba_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.red_out, rsp_chan.green_out, rsp_chan.blue_out,
                rsp_chan.alpha_out, rsp_chan.keyed_out};
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected rsp rgba %h %h %h %h keyed %b", $realtime,
                        got.red, got.green, got.blue, got.alpha, got.keyed);
         end else begin
            want = pending_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha ||
                got.keyed !== want.keyed) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"%0t: rsp mismatch, expected rgba %h %h %h %h keyed %b,",
                            " got %h %h %h %h keyed %b"},
                           $realtime, want.red, want.green, want.blue, want.alpha,
                           want.keyed, got.red, got.green, got.blue, got.alpha,
                           got.keyed);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long without any transaction on any channel
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule

### hsv_range_color_key.f
design/hsvk_pkg.sv
design/hsvk_if.sv
design/hsvk_front.sv
design/hsvk_div_stage.sv
design/hsvk_window.sv
design/hsv_range_color_key.sv
dv/testbench.sv
